>>> src/pps_pkg.sv
// shared constants and types for the pwm prescaler / period search core
// no dependencies
package pps_pkg;

    localparam int DIV_W           = 30;
    localparam int DIV_STEPS       = DIV_W;
    localparam int CNT_W           = $clog2(DIV_STEPS);
    localparam int PSC_COUNT_DEF   = 4096;
    localparam int PERIOD_BITS_DEF = 16;

    localparam logic [DIV_W-1:0] CLK_RESET = DIV_W'(24000000);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV1 = 5'b00010,
        S_DIV2 = 5'b00100,
        S_DIV3 = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

>>> src/pwm_prescaler_period_search_core.sv
// a zero-frequency transaction raises the strobe in the next cycle; otherwise each prescaler
// tried runs three divisions on one restoring divider (two when the period is too wide or the
// search ends on a quotient below 2) and the strobe follows the last of them
// throughput: one transaction at a time; busy stays high through the strobe cycle
// the result is shown for one cycle on o_valid; the receiver cannot stall
// reset (synchronous, active low) returns to idle and loads source clock 24000000
module pwm_prescaler_period_search_core #(
    parameter int PRESCALER_COUNT = pps_pkg::PSC_COUNT_DEF,
    parameter int PERIOD_BITS     = pps_pkg::PERIOD_BITS_DEF,
    parameter int PSC_W           = (PRESCALER_COUNT > 1) ? $clog2(PRESCALER_COUNT) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [pps_pkg::DIV_W-1:0] i_source_clock_hz,
    input  logic                     start,
    output logic                     busy,
    input  logic [pps_pkg::DIV_W-1:0] i_frequency_hz,
    output logic                     o_valid,
    output logic                     o_found,
    output logic [PSC_W-1:0]         o_prescaler,
    output logic [PERIOD_BITS-1:0]   o_period,
    output logic [pps_pkg::DIV_W-1:0] o_error_hz
);
    import pps_pkg::*;

    localparam logic [PSC_W-1:0] LAST_PSC = PSC_W'(PRESCALER_COUNT - 1);

    t_state                 r_state, n_state;
    logic [DIV_W-1:0]       r_clk;
    logic [DIV_W-1:0]       r_freq, n_freq;
    logic [PSC_W-1:0]       r_p, n_p;
    logic [DIV_W-1:0]       r_divd, n_divd;
    logic [DIV_W-1:0]       r_per, n_per;
    logic [DIV_W-1:0]       r_rem, n_rem;
    logic [DIV_W-1:0]       r_quo, n_quo;
    logic [DIV_W-1:0]       r_den, n_den;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_found, n_found;
    logic [PSC_W-1:0]       r_best_psc, n_best_psc;
    logic [PERIOD_BITS-1:0] r_best_per, n_best_per;
    logic [DIV_W-1:0]       r_best_err, n_best_err;

    logic [DIV_W:0]   rem_sh;
    logic             ge;
    logic [DIV_W-1:0] step_rem;
    logic [DIV_W-1:0] step_quo;
    logic             last;
    logic [DIV_W-1:0] err;
    logic             per_fits;
    logic             better;

    // shared restoring divider step
    always_comb begin
        rem_sh   = {r_rem, r_quo[DIV_W-1]};
        ge       = rem_sh >= {1'b0, r_den};
        step_rem = ge ? DIV_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_W-1:0];
        step_quo = {r_quo[DIV_W-2:0], ge};
        last     = r_cnt == CNT_W'(DIV_STEPS - 1);
        err      = (step_quo > r_freq) ? (step_quo - r_freq) : (r_freq - step_quo);
        per_fits = (step_quo - DIV_W'(2)) >> PERIOD_BITS == '0;
        better   = !r_found || (err < r_best_err);
    end

    always_comb begin
        n_state    = r_state;
        n_freq     = r_freq;
        n_p        = r_p;
        n_divd     = r_divd;
        n_per      = r_per;
        n_rem      = step_rem;
        n_quo      = step_quo;
        n_den      = r_den;
        n_cnt      = r_cnt + CNT_W'(1);
        n_found    = r_found;
        n_best_psc = r_best_psc;
        n_best_per = r_best_per;
        n_best_err = r_best_err;
        case (r_state)
            S_IDLE: begin
                n_rem = r_rem;
                n_quo = r_quo;
                n_cnt = r_cnt;
                if (start) begin
                    n_freq     = i_frequency_hz;
                    n_found    = 1'b0;
                    n_best_psc = '0;
                    n_best_per = '0;
                    n_best_err = '0;
                    n_p        = '0;
                    if (i_frequency_hz == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_rem   = '0;
                        n_quo   = r_clk;
                        n_den   = DIV_W'(1);
                        n_cnt   = '0;
                        n_state = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                if (last) begin
                    n_divd  = step_quo;
                    n_rem   = '0;
                    n_quo   = step_quo;
                    n_den   = r_freq;
                    n_cnt   = '0;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (last) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (step_quo < DIV_W'(2)) begin
                        // divided clock only falls with p, so no later prescaler fits
                        n_state = S_DONE;
                    end else if (per_fits) begin
                        n_per   = step_quo - DIV_W'(2);
                        n_quo   = r_divd;
                        n_den   = step_quo;
                        n_state = S_DIV3;
                    end else if (r_p == LAST_PSC) begin
                        n_state = S_DONE;
                    end else begin
                        n_p     = r_p + PSC_W'(1);
                        n_quo   = r_clk;
                        n_den   = DIV_W'(r_p) + DIV_W'(2);
                        n_state = S_DIV1;
                    end
                end
            end
            S_DIV3: begin
                if (last) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (better) begin
                        n_found    = 1'b1;
                        n_best_psc = r_p;
                        n_best_per = PERIOD_BITS'(r_per);
                        n_best_err = err;
                    end
                    if ((better && err == '0) || r_p == LAST_PSC) begin
                        n_state = S_DONE;
                    end else begin
                        n_p     = r_p + PSC_W'(1);
                        n_quo   = r_clk;
                        n_den   = DIV_W'(r_p) + DIV_W'(2);
                        n_state = S_DIV1;
                    end
                end
            end
            S_DONE: begin
                n_rem   = r_rem;
                n_quo   = r_quo;
                n_cnt   = r_cnt;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clk   <= CLK_RESET;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_p     <= n_p;
            if (i_cfg_valid && o_cfg_ready) begin
                r_clk <= i_source_clock_hz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_freq     <= n_freq;
        r_divd     <= n_divd;
        r_per      <= n_per;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_den      <= n_den;
        r_best_psc <= n_best_psc;
        r_best_per <= n_best_per;
        r_best_err <= n_best_err;
    end

    // no register write in the cycle a transaction is taken
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign busy        = r_state != S_IDLE;
    assign o_valid     = r_state == S_DONE;
    assign o_found     = r_found;
    assign o_prescaler = r_best_psc;
    assign o_period    = r_best_per;
    assign o_error_hz  = r_best_err;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_prescaler == '0 && o_period == '0 && o_error_hz == '0))
        else $error("not-found result carries nonzero fields");

    a_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_frequency_hz == '0) |=> (o_valid && !o_found))
        else $error("zero frequency not reported as not found");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DIV_STEPS - 1))
        else $error("divider step count out of range");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $stable(r_state)) |-> !o_cfg_ready)
        else $error("configuration accepted during a search");

endmodule

>>> dv/tb_pwm_prescaler_period_search_core.sv
`timescale 1ns / 1ps
// self-checking testbench for pwm_prescaler_period_search_core: directed and random searches
// against a best-fit prescaler/period predictor kept in a small scoreboard class
// depends on pps_pkg and the core rtl only
module tb_pwm_prescaler_period_search_core;
    import pps_pkg::*;

    localparam int PSC_N    = PSC_COUNT_DEF;
    localparam int PER_W    = PERIOD_BITS_DEF;
    localparam int PSC_BITS = $clog2(PSC_N);
    localparam longint unsigned PER_MAX = (64'd1 << PER_W) - 1;
    localparam logic [DIV_W-1:0] FIELD_MAX = '1;

    typedef struct {
        logic [DIV_W-1:0]    freq;
        logic                found;
        logic [PSC_BITS-1:0] psc;
        logic [PER_W-1:0]    per;
        logic [DIV_W-1:0]    err;
    } t_fit;

    class t_fit_board;
        logic [DIV_W-1:0] src_clk;
        t_fit want_q[$];
        int failures;

        function new();
            src_clk  = CLK_RESET;
            failures = 0;
        endfunction

        function void set_clock(logic [DIV_W-1:0] v);
            src_clk = v;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function t_fit best_fit(logic [DIV_W-1:0] f);
            longint unsigned div_clk, quo, ach, e, best_e, p;
            bit exact;
            t_fit r;
            r.freq  = f;
            r.found = 1'b0;
            r.psc   = '0;
            r.per   = '0;
            r.err   = '0;
            best_e  = 0;
            exact   = 1'b0;
            if (f != 0) begin
                for (p = 0; p < PSC_N && !exact; p++) begin
                    div_clk = longint'(src_clk) / (p + 1);
                    quo     = div_clk / longint'(f);
                    if (quo >= 2 && quo - 2 <= PER_MAX) begin
                        ach = div_clk / quo;
                        e   = (ach > f) ? ach - f : f - ach;
                        if (!r.found || e < best_e) begin
                            r.found = 1'b1;
                            best_e  = e;
                            r.psc   = PSC_BITS'(p);
                            r.per   = PER_W'(quo - 2);
                            r.err   = DIV_W'(e);
                            exact   = (e == 0);
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note(logic [DIV_W-1:0] f);
            want_q.push_back(best_fit(f));
        endfunction

        function void check(logic fnd, logic [PSC_BITS-1:0] psc, logic [PER_W-1:0] per,
                            logic [DIV_W-1:0] err);
            t_fit w;
            if (want_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result transaction: found=%0d psc=%0d per=%0d err=%0d",
                             fnd, psc, per, err);
                return;
            end
            w = want_q.pop_front();
            if (w.found !== fnd || w.psc !== psc || w.per !== per || w.err !== err) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch freq=%0d clk=%0d exp found=%0d psc=%0d per=%0d err=%0d %s",
                             w.freq, src_clk, w.found, w.psc, w.per, w.err,
                             $sformatf("got found=%0d psc=%0d per=%0d err=%0d",
                                       fnd, psc, per, err));
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [DIV_W-1:0]    i_source_clock_hz;
    logic                start;
    logic                busy;
    logic [DIV_W-1:0]    i_frequency_hz;
    logic                o_valid;
    logic                o_found;
    logic [PSC_BITS-1:0] o_prescaler;
    logic [PER_W-1:0]    o_period;
    logic [DIV_W-1:0]    o_error_hz;

    t_fit_board sb;

    pwm_prescaler_period_search_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_source_clock_hz (i_source_clock_hz),
        .start             (start),
        .busy              (busy),
        .i_frequency_hz    (i_frequency_hz),
        .o_valid           (o_valid),
        .o_found           (o_found),
        .o_prescaler       (o_prescaler),
        .o_period          (o_period),
        .o_error_hz        (o_error_hz)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check(o_found, o_prescaler, o_period, o_error_hz);
    end

    task automatic write_clock(input logic [DIV_W-1:0] v);
        i_cfg_valid       <= 1'b1;
        i_source_clock_hz <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_clock(v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send(input logic [DIV_W-1:0] f);
        int g;
        i_frequency_hz <= f;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note(f);
        g = $urandom_range(0, 9);
        if (g >= 5) begin
            start <= 1'b0;
            repeat ((g == 9) ? $urandom_range(10, 60) : $urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        logic [DIV_W-1:0] c, f;
        longint unsigned w;
        int r;
        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_source_clock_hz = '0;
        start             = 1'b0;
        i_frequency_hz    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset clock of 24 MHz: zero frequency, exact hits, ties, nothing fits
        send('0);
        send(30'd1);
        send(30'd1000);
        send(30'd5_000_000);
        send(30'd7_000_000);
        send(30'd12_000_000);
        send(30'd24_000_000);
        send(30'd1_000_007);
        send(FIELD_MAX);
        drain();

        // period too wide for every prescaler, then a frequency equal to the clock (quotient below 2)
        write_clock(30'd1_000_000_000);
        send(30'd1);
        send(30'd1_000_000_000);
        drain();

        write_clock(FIELD_MAX);
        send(30'h1FFF_FFFF);
        send(FIELD_MAX);
        drain();

        write_clock('0);
        send(30'd1);
        send(30'd12345);
        drain();

        write_clock(30'd1);
        send(30'd1);
        drain();

        write_clock(30'd2);
        send(30'd1);
        drain();

        // period exactly at the top, then one past it
        write_clock(30'd65_537_000);
        send(30'd1000);
        drain();

        write_clock(30'd65_538_000);
        send(30'd1000);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: c = 30'($urandom);
                1: c = 30'd24_000_000;
                2: c = 30'($urandom_range(1000, 100_000_000));
                3: c = 30'd1_000_000_000;
                default: c = 30'($urandom_range(1, 1 << 20));
            endcase
            write_clock(c);
            repeat (20) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    f = '0;
                end else if (r < 20) begin
                    f = 30'($urandom);
                end else if (r < 35) begin
                    f = c / 30'($urandom_range(2, 16));
                end else if (r < 97) begin
                    w = c / $urandom_range(2, 256) + $urandom_range(0, 7);
                    f = (w > FIELD_MAX) ? FIELD_MAX : 30'(w);
                end else begin
                    f = c / 30'($urandom_range(500, 4000));
                end
                send(f);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
